// ===== design/qcr_pkg.sv =====
package qcr_pkg;

  localparam int DW = 32;
  localparam int FRAC = 30;
  localparam int AW = 6;
  localparam int RAM_DEPTH = 64;
  localparam int IDX_W = 6;

  // half angle in Q.30 = floor((m * PI30 + 23040) / 46080), split as
  // m * PI_QUOT + floor((m * PI_REM + 23040) / 46080); the /1024 part is a shift
  localparam logic [31:0] PI30 = 32'd3373259426;
  localparam logic [33:0] HALFPI30 = 34'd1686629713;
  localparam logic [33:0] GAIN30 = 34'd652032874;
  localparam logic [14:0] ROUND_ADD = 15'd23040;
  localparam logic [16:0] PI_QUOT = 17'd73204;
  localparam logic [14:0] PI_REM = 15'd19106;
  // ceil(2^26 / 45), exact for dividends below 2^20
  localparam logic [20:0] RECIP45 = 21'd1491309;
  localparam int DIV_STEPS = 2;

  localparam logic [DW-1:0] ONE = 32'h4000_0000;
  localparam int INIT_WORDS = 20;

  localparam logic [1:0] OP_YAW = 2'd0;
  localparam logic [1:0] OP_PITCH = 2'd1;
  localparam logic [1:0] OP_ROLL = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // scratch store map
  localparam logic [AW-1:0] A_Q = 6'd0;
  localparam logic [AW-1:0] A_FWD = 6'd4;
  localparam logic [AW-1:0] A_HOR = 6'd8;
  localparam logic [AW-1:0] A_VER = 6'd12;
  localparam logic [AW-1:0] A_DEP = 6'd16;
  localparam logic [AW-1:0] A_LOC = 6'd20;
  localparam logic [AW-1:0] A_NT = 6'd24;
  localparam logic [AW-1:0] A_R = 6'd28;
  localparam logic [AW-1:0] A_P = 6'd32;
  localparam logic [AW-1:0] A_S = 6'd41;
  localparam logic [AW-1:0] A_M = 6'd48;

  localparam logic [6:0] PC_LAST = 7'd76;

  typedef struct packed {
    logic [1:0] operation;
    logic signed [15:0] angle_deg;
  } in_t;

  typedef struct packed {
    logic signed [31:0] forward_x;
    logic signed [31:0] forward_y;
    logic signed [31:0] forward_z;
    logic signed [31:0] rot_w;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
  } out_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_ANG, ST_DIV, ST_CLD, ST_CORD, ST_WCOS, ST_WSIN,
    ST_ISSUE, ST_EXEC, ST_ACC, ST_WRITE, ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    RG_Q, RG_FWD, RG_AXIS, RG_O1, RG_O2, RG_LOC, RG_NT, RG_R, RG_P, RG_M, RG_S
  } rg_t;

  typedef enum logic {UK_MAC, UK_ALU} uk_t;

  typedef enum logic [1:0] {ALU_COPY, ALU_ONE2S, ALU_2DIF, ALU_2SUM} alu_fn_t;

  typedef enum logic [2:0] {WS_NONE, WS_INIT, WS_COS, WS_SIN, WS_ACC, WS_ALU} wsrc_t;

  typedef struct packed {
    uk_t kind;
    alu_fn_t fn;
    rg_t a_rg;
    logic [3:0] a_off;
    rg_t b_rg;
    logic [3:0] b_off;
    rg_t d_rg;
    logic [3:0] d_off;
    logic first;
    logic last;
    logic neg;
  } uop_t;

  typedef struct packed {
    logic ld_in;
    logic ang;
    logic div_step;
    logic cord_ld;
    logic cord_step;
    logic mul;
    logic acc_add;
    logic acc_clr;
    logic neg;
    logic [IDX_W-1:0] idx;
    alu_fn_t alu_fn;
    wsrc_t wsrc;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
  } sts_t;

  // quaternion product terms k = 4*t + j: a = loc[j], b = q[j ^ t]
  localparam logic [15:0] QP_NEG = 16'h428E;

  // pair products xx yy zz xy xz yz wx wy wz
  localparam logic [3:0] PA [9] = '{4'd1, 4'd2, 4'd3, 4'd1, 4'd1, 4'd2, 4'd0, 4'd0, 4'd0};
  localparam logic [3:0] PB [9] = '{4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd3, 4'd1, 4'd2, 4'd3};

  // rotation matrix entries from the pair products
  localparam alu_fn_t MF [9] = '{ALU_ONE2S, ALU_2DIF, ALU_2SUM, ALU_2SUM, ALU_ONE2S,
                                 ALU_2DIF, ALU_2DIF, ALU_2SUM, ALU_ONE2S};
  localparam logic [3:0] MA [9] = '{4'd1, 4'd3, 4'd4, 4'd3, 4'd0, 4'd5, 4'd4, 4'd5, 4'd0};
  localparam logic [3:0] MB [9] = '{4'd2, 4'd8, 4'd7, 4'd8, 4'd2, 4'd6, 4'd7, 4'd6, 4'd1};

  localparam logic [3:0] VI [9] = '{4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2};
  localparam logic [3:0] VJ [9] = '{4'd0, 4'd1, 4'd2, 4'd0, 4'd1, 4'd2, 4'd0, 4'd1, 4'd2};

  function automatic logic [30:0] atan_q30(input logic [IDX_W-1:0] i);
    logic [30:0] r;
    unique case (i)
      6'd0: r = 31'd843314857;
      6'd1: r = 31'd497837829;
      6'd2: r = 31'd263043837;
      6'd3: r = 31'd133525159;
      6'd4: r = 31'd67021687;
      6'd5: r = 31'd33543516;
      6'd6: r = 31'd16775851;
      6'd7: r = 31'd8388437;
      6'd8: r = 31'd4194283;
      6'd9: r = 31'd2097149;
      default: r = (i <= 6'd30) ? (31'd1 << (6'd30 - i)) : 31'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_unit(input logic [AW-1:0] a);
    return (a == A_Q) || (a == A_FWD + 6'd2) || (a == A_HOR) ||
           (a == A_VER + 6'd1) || (a == A_DEP + 6'd2);
  endfunction

  function automatic uop_t ucode(input logic [6:0] pc);
    uop_t u;
    logic [6:0] k;
    logic [3:0] r;
    rg_t vg;
    u.kind = UK_MAC;
    u.fn = ALU_COPY;
    u.a_rg = RG_Q;
    u.a_off = 4'd0;
    u.b_rg = RG_Q;
    u.b_off = 4'd0;
    u.d_rg = RG_Q;
    u.d_off = 4'd0;
    u.first = 1'b1;
    u.last = 1'b1;
    u.neg = 1'b0;
    k = 7'd0;
    r = 4'd0;
    vg = RG_FWD;
    if (pc < 7'd3) begin
      // local quaternion vector part: s * axis
      u.a_rg = RG_S;
      u.b_rg = RG_AXIS;
      u.b_off = pc[3:0];
      u.d_rg = RG_LOC;
      u.d_off = pc[3:0] + 4'd1;
    end else if (pc < 7'd19) begin
      k = pc - 7'd3;
      u.a_rg = RG_LOC;
      u.a_off = {2'b00, k[1:0]};
      u.b_off = {2'b00, k[1:0] ^ k[3:2]};
      u.neg = QP_NEG[k[3:0]];
      u.first = (k[1:0] == 2'd0);
      u.last = (k[1:0] == 2'd3);
      u.d_rg = RG_NT;
      u.d_off = {2'b00, k[3:2]};
    end else if (pc < 7'd23) begin
      k = pc - 7'd19;
      u.kind = UK_ALU;
      u.a_rg = RG_NT;
      u.a_off = k[3:0];
      u.d_off = k[3:0];
    end else if (pc < 7'd32) begin
      k = pc - 7'd23;
      u.a_rg = RG_LOC;
      u.a_off = PA[k[3:0]];
      u.b_rg = RG_LOC;
      u.b_off = PB[k[3:0]];
      u.d_rg = RG_P;
      u.d_off = k[3:0];
    end else if (pc < 7'd41) begin
      k = pc - 7'd32;
      u.kind = UK_ALU;
      u.fn = MF[k[3:0]];
      u.a_rg = RG_P;
      u.a_off = MA[k[3:0]];
      u.b_rg = RG_P;
      u.b_off = MB[k[3:0]];
      u.d_rg = RG_M;
      u.d_off = k[3:0];
    end else begin
      k = pc - 7'd41;
      if (k < 7'd12) begin
        vg = RG_FWD;
        r = k[3:0];
      end else if (k < 7'd24) begin
        vg = RG_O1;
        r = 4'(k - 7'd12);
      end else begin
        vg = RG_O2;
        r = 4'(k - 7'd24);
      end
      if (r < 4'd9) begin
        u.a_rg = vg;
        u.a_off = VJ[r];
        u.b_rg = RG_M;
        u.b_off = r;
        u.d_rg = RG_R;
        u.d_off = VI[r];
        u.first = (VJ[r] == 4'd0);
        u.last = (VJ[r] == 4'd2);
      end else begin
        u.kind = UK_ALU;
        u.a_rg = RG_R;
        u.a_off = r - 4'd9;
        u.d_rg = vg;
        u.d_off = r - 4'd9;
      end
    end
    return u;
  endfunction

endpackage

// ===== design/qcr_ram.sv =====
module qcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== design/qcr_datapath.sv =====
module qcr_datapath (
  input  logic          clk,
  input  qcr_pkg::in_t  in_data,
  input  qcr_pkg::cmd_t cmd,
  output qcr_pkg::sts_t sts,
  output qcr_pkg::out_t out_data
);

  logic [1:0] op_r;
  logic signed [15:0] ang_r;
  logic [31:0] hq_r;
  logic [29:0] fr_r;
  logic [13:0] q45_r;
  logic [31:0] h_r;
  logic signed [33:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic negcos_r, negcos_nxt;
  logic signed [63:0] prod_r, acc_r, acc_nxt;
  logic [qcr_pkg::DW-1:0] rot_sh [4];
  logic [qcr_pkg::DW-1:0] fwd_sh [3];
  qcr_pkg::out_t out_r;

  logic [qcr_pkg::DW-1:0] rd_a, rd_b, wdata, alu_y, sum_ab, dif_ab;
  logic [63:0] acc_rnd;
  logic we;

  logic signed [16:0] a17;
  logic [16:0] mag;
  logic [33:0] mul_hq;
  logic [31:0] mul_fr;
  logic [40:0] mul_q;
  logic [33:0] h;
  logic signed [33:0] xs, ys, at, cosv, sinv;

  assign sts.op = op_r;
  assign out_data = out_r;

  qcr_ram #(
    .WIDTH (qcr_pkg::DW),
    .DEPTH (qcr_pkg::RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (cmd.waddr),
    .wdata   (wdata),
    .raddr_a (cmd.raddr_a),
    .raddr_b (cmd.raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // angle scaling: whole part by one product, the /45 by a reciprocal multiply
  always_comb begin
    a17 = {ang_r[15], ang_r};
    mag = ang_r[15] ? 17'(-a17) : 17'(a17);
    mul_hq = 34'(mag) * 34'(qcr_pkg::PI_QUOT);
    mul_fr = 32'(mag) * 32'(qcr_pkg::PI_REM) + 32'(qcr_pkg::ROUND_ADD);
    mul_q = 41'(fr_r[29:10]) * 41'(qcr_pkg::RECIP45);
  end

  // CORDIC rotation mode, one step a cycle
  always_comb begin
    h = {2'b00, h_r};
    xs = x_r >>> cmd.idx;
    ys = y_r >>> cmd.idx;
    at = $signed({3'b000, qcr_pkg::atan_q30(cmd.idx)});
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    negcos_nxt = negcos_r;
    if (cmd.cord_ld) begin
      x_nxt = $signed(qcr_pkg::GAIN30);
      y_nxt = 34'sd0;
      if (h > qcr_pkg::HALFPI30) begin
        z_nxt = $signed(34'(qcr_pkg::PI30) - h);
        negcos_nxt = 1'b1;
      end else begin
        z_nxt = $signed(h);
        negcos_nxt = 1'b0;
      end
    end else if (cmd.cord_step) begin
      if (!z_r[33]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
    end
    cosv = negcos_r ? -x_r : x_r;
    sinv = ang_r[15] ? -y_r : y_r;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.acc_add) begin
      acc_nxt = (cmd.acc_clr ? 64'sd0 : acc_r) + (cmd.neg ? -prod_r : prod_r);
    end
    acc_rnd = acc_r + (64'd1 << (qcr_pkg::FRAC - 1));
  end

  always_comb begin
    sum_ab = rd_a + rd_b;
    dif_ab = rd_a - rd_b;
    unique case (cmd.alu_fn)
      qcr_pkg::ALU_COPY:  alu_y = rd_a;
      qcr_pkg::ALU_ONE2S: alu_y = qcr_pkg::ONE - {sum_ab[qcr_pkg::DW-2:0], 1'b0};
      qcr_pkg::ALU_2DIF:  alu_y = {dif_ab[qcr_pkg::DW-2:0], 1'b0};
      qcr_pkg::ALU_2SUM:  alu_y = {sum_ab[qcr_pkg::DW-2:0], 1'b0};
      default:            alu_y = rd_a;
    endcase
  end

  always_comb begin
    we = (cmd.wsrc != qcr_pkg::WS_NONE);
    unique case (cmd.wsrc)
      qcr_pkg::WS_INIT: wdata = qcr_pkg::is_unit(cmd.waddr) ? qcr_pkg::ONE : '0;
      qcr_pkg::WS_COS:  wdata = cosv[qcr_pkg::DW-1:0];
      qcr_pkg::WS_SIN:  wdata = sinv[qcr_pkg::DW-1:0];
      qcr_pkg::WS_ACC:  wdata = acc_rnd[qcr_pkg::FRAC +: qcr_pkg::DW];
      qcr_pkg::WS_ALU:  wdata = alu_y;
      default:          wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      op_r <= in_data.operation;
      ang_r <= in_data.angle_deg;
    end
    if (cmd.ang) begin
      hq_r <= mul_hq[31:0];
      fr_r <= mul_fr[29:0];
    end
    // two steps: quotient by 45, then the sum
    if (cmd.div_step) begin
      q45_r <= mul_q[39:26];
      h_r <= hq_r + 32'(q45_r);
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    negcos_r <= negcos_nxt;
    if (cmd.mul) begin
      prod_r <= $signed(rd_a) * $signed(rd_b);
    end
    acc_r <= acc_nxt;
    // shadow copies of the reported words
    if (we && cmd.waddr[5:2] == qcr_pkg::A_Q[5:2]) begin
      rot_sh[cmd.waddr[1:0]] <= wdata;
    end
    if (we && cmd.waddr[5:2] == qcr_pkg::A_FWD[5:2] && cmd.waddr[1:0] != 2'd3) begin
      fwd_sh[cmd.waddr[1:0]] <= wdata;
    end
    if (cmd.out_load) begin
      out_r.forward_x <= fwd_sh[0];
      out_r.forward_y <= fwd_sh[1];
      out_r.forward_z <= fwd_sh[2];
      out_r.rot_w <= rot_sh[0];
      out_r.rot_x <= rot_sh[1];
      out_r.rot_y <= rot_sh[2];
      out_r.rot_z <= rot_sh[3];
    end
  end

endmodule

// ===== design/qcr_ctrl.sv =====
module qcr_ctrl #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  qcr_pkg::sts_t sts,
  output qcr_pkg::cmd_t cmd
);

  qcr_pkg::state_t state_r, state_nxt;
  logic [qcr_pkg::IDX_W-1:0] cnt_r, cnt_nxt;
  logic [6:0] pc_r, pc_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  qcr_pkg::uop_t u;

  function automatic logic [qcr_pkg::AW-1:0] rg_addr(input qcr_pkg::rg_t rg,
                                                     input logic [3:0] off,
                                                     input logic [1:0] op);
    logic [qcr_pkg::AW-1:0] b;
    unique case (rg)
      qcr_pkg::RG_Q:    b = qcr_pkg::A_Q;
      qcr_pkg::RG_FWD:  b = qcr_pkg::A_FWD;
      qcr_pkg::RG_AXIS: b = (op == qcr_pkg::OP_YAW) ? qcr_pkg::A_VER :
                            (op == qcr_pkg::OP_PITCH) ? qcr_pkg::A_HOR : qcr_pkg::A_DEP;
      qcr_pkg::RG_O1:   b = (op == qcr_pkg::OP_PITCH) ? qcr_pkg::A_VER : qcr_pkg::A_HOR;
      qcr_pkg::RG_O2:   b = (op == qcr_pkg::OP_ROLL) ? qcr_pkg::A_VER : qcr_pkg::A_DEP;
      qcr_pkg::RG_LOC:  b = qcr_pkg::A_LOC;
      qcr_pkg::RG_NT:   b = qcr_pkg::A_NT;
      qcr_pkg::RG_R:    b = qcr_pkg::A_R;
      qcr_pkg::RG_P:    b = qcr_pkg::A_P;
      qcr_pkg::RG_M:    b = qcr_pkg::A_M;
      qcr_pkg::RG_S:    b = qcr_pkg::A_S;
      default:          b = qcr_pkg::A_Q;
    endcase
    return b + {2'b00, off};
  endfunction

  assign u = qcr_pkg::ucode(pc_r);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != qcr_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qcr_pkg::ST_INIT:
        if (cnt_r == qcr_pkg::IDX_W'(qcr_pkg::INIT_WORDS - 1)) state_nxt = qcr_pkg::ST_IDLE;
      qcr_pkg::ST_IDLE:
        if (in_valid) state_nxt = qcr_pkg::ST_ANG;
      qcr_pkg::ST_ANG:
        state_nxt = (sts.op == qcr_pkg::OP_NONE) ? qcr_pkg::ST_FIN : qcr_pkg::ST_DIV;
      qcr_pkg::ST_DIV:
        if (cnt_r == qcr_pkg::IDX_W'(qcr_pkg::DIV_STEPS - 1)) state_nxt = qcr_pkg::ST_CLD;
      qcr_pkg::ST_CLD:
        state_nxt = qcr_pkg::ST_CORD;
      qcr_pkg::ST_CORD:
        if (cnt_r == qcr_pkg::IDX_W'(CORDIC_STEPS - 1)) state_nxt = qcr_pkg::ST_WCOS;
      qcr_pkg::ST_WCOS:
        state_nxt = qcr_pkg::ST_WSIN;
      qcr_pkg::ST_WSIN:
        state_nxt = qcr_pkg::ST_ISSUE;
      qcr_pkg::ST_ISSUE:
        state_nxt = qcr_pkg::ST_EXEC;
      qcr_pkg::ST_EXEC:
        if (u.kind == qcr_pkg::UK_MAC) begin
          state_nxt = qcr_pkg::ST_ACC;
        end else begin
          state_nxt = (pc_r == qcr_pkg::PC_LAST) ? qcr_pkg::ST_FIN : qcr_pkg::ST_ISSUE;
        end
      qcr_pkg::ST_ACC:
        state_nxt = u.last ? qcr_pkg::ST_WRITE : qcr_pkg::ST_ISSUE;
      qcr_pkg::ST_WRITE:
        state_nxt = (pc_r == qcr_pkg::PC_LAST) ? qcr_pkg::ST_FIN : qcr_pkg::ST_ISSUE;
      qcr_pkg::ST_FIN:
        if (out_free) state_nxt = qcr_pkg::ST_IDLE;
      default:
        state_nxt = qcr_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cnt_nxt = (state_nxt != state_r) ? '0 : cnt_r + 1'b1;
    pc_nxt = pc_r;
    if (state_r == qcr_pkg::ST_IDLE) begin
      pc_nxt = 7'd0;
    end else if ((state_r == qcr_pkg::ST_EXEC && u.kind == qcr_pkg::UK_ALU) ||
                 (state_r == qcr_pkg::ST_ACC && !u.last) ||
                 state_r == qcr_pkg::ST_WRITE) begin
      pc_nxt = pc_r + 7'd1;
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.wsrc = qcr_pkg::WS_NONE;
    cmd.alu_fn = u.fn;
    cmd.raddr_a = rg_addr(u.a_rg, u.a_off, sts.op);
    cmd.raddr_b = rg_addr(u.b_rg, u.b_off, sts.op);
    cmd.idx = cnt_r;
    cmd.neg = u.neg;
    cmd.acc_clr = u.first;
    unique case (state_r)
      qcr_pkg::ST_INIT: begin
        cmd.wsrc = qcr_pkg::WS_INIT;
        cmd.waddr = cnt_r;
      end
      qcr_pkg::ST_IDLE:  cmd.ld_in = in_valid;
      qcr_pkg::ST_ANG:   cmd.ang = 1'b1;
      qcr_pkg::ST_DIV:   cmd.div_step = 1'b1;
      qcr_pkg::ST_CLD:   cmd.cord_ld = 1'b1;
      qcr_pkg::ST_CORD:  cmd.cord_step = 1'b1;
      qcr_pkg::ST_WCOS: begin
        cmd.wsrc = qcr_pkg::WS_COS;
        cmd.waddr = qcr_pkg::A_LOC;
      end
      qcr_pkg::ST_WSIN: begin
        cmd.wsrc = qcr_pkg::WS_SIN;
        cmd.waddr = qcr_pkg::A_S;
      end
      qcr_pkg::ST_ISSUE: ;
      qcr_pkg::ST_EXEC: begin
        if (u.kind == qcr_pkg::UK_MAC) begin
          cmd.mul = 1'b1;
        end else begin
          cmd.wsrc = qcr_pkg::WS_ALU;
          cmd.waddr = rg_addr(u.d_rg, u.d_off, sts.op);
        end
      end
      qcr_pkg::ST_ACC:   cmd.acc_add = 1'b1;
      qcr_pkg::ST_WRITE: begin
        cmd.wsrc = qcr_pkg::WS_ACC;
        cmd.waddr = rg_addr(u.d_rg, u.d_off, sts.op);
      end
      qcr_pkg::ST_FIN:   cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qcr_pkg::ST_INIT;
      cnt_r <= '0;
      pc_r <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      pc_r <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/quaternion_camera_rotator_top.sv =====
// channel  dir  handshake           beat payload
// in_      in   in_valid/in_stall   qcr_pkg::in_t  (operation, angle_deg)
// out_     out  out_valid/out_stall qcr_pkg::out_t (forward_xyz, rot_wxyz)
//
// A no-op item goes from the angle step straight to the output and skips the rest.
// The time goes on the angle scaling, the CORDIC (one step a cycle) and
// 77 microcoded steps on the single 32x32 multiplier and scratch RAM.
// After reset the frame is written into the first 20 scratch RAM words; no item is taken meanwhile.
// A finished beat sits in the output register; the next item is taken meanwhile and
// only waits at its end if the previous beat is still stalled.
module quaternion_camera_rotator_top #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  qcr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output qcr_pkg::out_t out_data
);

  qcr_pkg::cmd_t cmd;
  qcr_pkg::sts_t sts;

  qcr_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  qcr_datapath u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
